[hdl/midi_active_note_tracker_defines.svh]
// Assertion macros for the active note tracker.
`ifndef MIDI_ACTIVE_NOTE_TRACKER_DEFINES_SVH
`define MIDI_ACTIVE_NOTE_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define MANT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MANT_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MANT_ASSERT(label, clk, rstn, prop, msg)
`define MANT_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

[hdl/mant_pkg.sv]
// ----------------------------------------------------------------------------
// mant_pkg
// Shared types and event codes of the active note tracker.
// ----------------------------------------------------------------------------
package mant_pkg;
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_NOTE    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    // The spare kind code is decoded as a time tick.
    localparam logic [1:0] KIND_SPARE   = 2'd3;

    localparam logic [2:0] EV_OFF  = 3'd0;
    localparam logic [2:0] EV_PROG = 3'd1;
    localparam logic [2:0] EV_ON   = 3'd2;
    localparam logic [2:0] EV_OVER = 3'd3;
    localparam logic [2:0] EV_DONE = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic [3:0]  channel;
        logic [6:0]  note_num;
        logic [6:0]  velocity;
        logic [6:0]  program_req;
        logic [31:0] end_ms;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [3:0]  out_channel;
        logic [6:0]  out_note;
        logic [6:0]  out_velocity;
        logic [6:0]  out_program;
        logic [31:0] next_end_ms;
        logic        has_next_end;
        logic [5:0]  active_voices;
        logic        last;
    } out_beat_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic        is_note;
        logic        is_release;
        logic        prog_change;
        logic [31:0] now_ms;
        logic [3:0]  channel;
        logic [6:0]  note_num;
        logic [6:0]  velocity;
        logic [6:0]  program_req;
        logic [31:0] end_ms;
    } cmd_t;
endpackage

[hdl/mant_front.sv]
// ----------------------------------------------------------------------------
// mant_front
// Accepts input beats, tracks channel programs and queues classified commands.
// ----------------------------------------------------------------------------
`include "midi_active_note_tracker_defines.svh"
module mant_front
    import mant_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  in_beat_t s_beat,
    input  logic     s_valid,
    output logic     s_ready,
    output cmd_t     q_cmd,
    output logic     q_valid,
    input  logic     q_pop
);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [6:0] prog_reg [CHANNELS];
    logic [6:0] prog_next [CHANNELS];
    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       cmd;
    logic       push, ch_ok;
    logic [CW-1:0] ch_idx;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = slot_reg[rd_ptr_reg];
    assign ch_ok   = ({28'd0, s_beat.channel} < 32'(CHANNELS));
    assign ch_idx  = CW'(s_beat.channel);

    always_comb begin
        cmd.is_note     = (s_beat.kind == KIND_NOTE);
        cmd.is_release  = (s_beat.kind == KIND_RELEASE);
        cmd.prog_change = cmd.is_note && ch_ok && (prog_reg[ch_idx] != s_beat.program_req);
        cmd.now_ms      = s_beat.now_ms;
        cmd.channel     = s_beat.channel;
        cmd.note_num    = s_beat.note_num;
        cmd.velocity    = s_beat.velocity;
        cmd.program_req = s_beat.program_req;
        cmd.end_ms      = s_beat.end_ms;
        prog_next = prog_reg;
        if (push && cmd.prog_change) begin
            prog_next[ch_idx] = s_beat.program_req;
        end
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) prog_reg[c] <= 7'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            prog_reg <= prog_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
        if (push) slot_reg[wr_ptr_reg] <= cmd;
    end

    `MANT_ASSERT(a_q_bound, aclk, aresetn, cnt_reg <= 2'd2, "queue count out of range")
    `MANT_ASSERT(a_no_pop_empty, aclk, aresetn, q_pop |-> q_valid, "pop from empty queue")
    `MANT_ASSERT(a_full_stall, aclk, aresetn, (cnt_reg == 2'd2) |-> !s_ready, "accept when full")
endmodule

[hdl/mant_back.sv]
// ----------------------------------------------------------------------------
// mant_back
// Walks the voice table for one command and emits the result beats.
// ----------------------------------------------------------------------------
`include "midi_active_note_tracker_defines.svh"
module mant_back
    import mant_pkg::*;
#(
    parameter int VOICES = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cmd_t      q_cmd,
    input  logic      q_valid,
    output logic      q_pop,
    output out_beat_t m_beat,
    output logic      m_valid,
    input  logic      m_ready
);
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [5:0] VMAX = 6'(VOICES);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WALK = 3'd1;
    localparam logic [2:0] ST_PROG = 3'd2;
    localparam logic [2:0] ST_OFF  = 3'd3;
    localparam logic [2:0] ST_ON   = 3'd4;
    localparam logic [2:0] ST_MIN  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;
    localparam logic [2:0] ST_SCAN = 3'd7;

    logic [2:0]  st_reg, st_next;
    cmd_t        cmd_reg, cmd_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [5:0]  idx_reg, idx_next;
    logic        found_reg, found_next;
    logic [VW-1:0] match_reg, match_next;
    logic [31:0] best_reg, best_next;
    logic        has_reg, has_next;
    logic [3:0]  tch [VOICES];
    logic [6:0]  tnote [VOICES];
    logic [31:0] tend [VOICES];
    out_beat_t   ob_reg, ob_next;
    logic        ov_reg, ov_next;
    logic        wr_en;
    logic [VW-1:0] wr_idx;
    logic [3:0]  wr_ch;
    logic [6:0]  wr_note;
    logic [31:0] wr_end;
    logic        out_free;
    logic [VW-1:0] ci, li;
    logic [5:0]  fin_reg, fin_next;
    logic [5:0]  pcnt_reg, pcnt_next;
    logic        pfound_reg, pfound_next;

    assign out_free = !ov_reg || m_ready;
    assign m_valid  = ov_reg;
    assign m_beat   = ob_reg;
    assign ci = idx_reg[VW-1:0];
    assign li = VW'(cnt_reg - 6'd1);

    function automatic out_beat_t mk(input logic [2:0] ev, input logic [3:0] ch,
                                     input logic [6:0] nt, input logic [6:0] vel,
                                     input logic [6:0] pg, input logic [5:0] av);
        out_beat_t b;
        b = '0;
        b.event_res = ev;
        b.out_channel = ch;
        b.out_note = nt;
        b.out_velocity = vel;
        b.out_program = pg;
        b.active_voices = av;
        return b;
    endfunction

    always_comb begin
        st_next = st_reg;
        cmd_next = cmd_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        found_next = found_reg;
        match_next = match_reg;
        best_next = best_reg;
        has_next = has_reg;
        fin_next = fin_reg;
        pcnt_next = pcnt_reg;
        pfound_next = pfound_reg;
        ob_next = ob_reg;
        ov_next = ov_reg && !m_ready;
        q_pop = 1'b0;
        wr_en = 1'b0;
        wr_idx = ci;
        wr_ch = tch[li];
        wr_note = tnote[li];
        wr_end = tend[li];
        case (st_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    cmd_next = q_cmd;
                    idx_next = 6'd0;
                    found_next = 1'b0;
                    pcnt_next = 6'd0;
                    pfound_next = 1'b0;
                    st_next = ST_SCAN;
                end
            end
            // Read-only pass that finds the voice count at the end of the item,
            // since every beat of the item reports it.
            ST_SCAN: begin
                if (idx_reg >= cnt_reg) begin
                    idx_next = 6'd0;
                    st_next = ST_WALK;
                    if (cmd_reg.is_release) begin
                        fin_next = 6'd0;
                    end else if (cmd_reg.is_note && !pfound_reg && pcnt_reg < VMAX) begin
                        fin_next = pcnt_reg + 6'd1;
                    end else begin
                        fin_next = pcnt_reg;
                    end
                end else begin
                    if (tend[ci] > cmd_reg.now_ms) begin
                        pcnt_next = pcnt_reg + 6'd1;
                        if (cmd_reg.is_note && tch[ci] == cmd_reg.channel &&
                            tnote[ci] == cmd_reg.note_num) begin
                            pfound_next = 1'b1;
                        end
                    end
                    idx_next = idx_reg + 6'd1;
                end
            end
            ST_WALK: begin
                if (idx_reg >= cnt_reg) begin
                    if (cmd_reg.is_release) cnt_next = 6'd0;
                    st_next = cmd_reg.is_note ? ST_PROG : ST_MIN;
                    idx_next = 6'd0;
                    has_next = 1'b0;
                    best_next = 32'd0;
                end else if (cmd_reg.is_release) begin
                    if (out_free) begin
                        ov_next = 1'b1;
                        ob_next = mk(EV_OFF, tch[ci], tnote[ci], 7'd0, 7'd0, 6'd0);
                        idx_next = idx_reg + 6'd1;
                    end
                end else if (tend[ci] <= cmd_reg.now_ms) begin
                    if (out_free) begin
                        ov_next = 1'b1;
                        ob_next = mk(EV_OFF, tch[ci], tnote[ci], 7'd0, 7'd0, 6'd0);
                        wr_en = (idx_reg + 6'd1 < cnt_reg);
                        cnt_next = cnt_reg - 6'd1;
                    end
                end else begin
                    if (cmd_reg.is_note && tch[ci] == cmd_reg.channel &&
                        tnote[ci] == cmd_reg.note_num) begin
                        found_next = 1'b1;
                        match_next = ci;
                    end
                    idx_next = idx_reg + 6'd1;
                end
            end
            ST_PROG: begin
                if (!cmd_reg.prog_change) begin
                    st_next = ST_OFF;
                end else if (out_free) begin
                    ov_next = 1'b1;
                    ob_next = mk(EV_PROG, cmd_reg.channel, 7'd0, 7'd0,
                                 cmd_reg.program_req, 6'd0);
                    st_next = ST_OFF;
                end
            end
            ST_OFF: begin
                if (found_reg) begin
                    if (out_free) begin
                        ov_next = 1'b1;
                        ob_next = mk(EV_OFF, cmd_reg.channel, cmd_reg.note_num,
                                     7'd0, 7'd0, 6'd0);
                        st_next = ST_ON;
                    end
                end else if (cnt_reg < VMAX) begin
                    match_next = VW'(cnt_reg);
                    cnt_next = cnt_reg + 6'd1;
                    found_next = 1'b1;
                    st_next = ST_ON;
                end else begin
                    st_next = ST_ON;
                end
            end
            ST_ON: begin
                if (out_free) begin
                    ov_next = 1'b1;
                    if (found_reg) begin
                        ob_next = mk(EV_ON, cmd_reg.channel, cmd_reg.note_num,
                                     cmd_reg.velocity, 7'd0, 6'd0);
                        wr_en = 1'b1;
                        wr_idx = match_reg;
                        wr_ch = cmd_reg.channel;
                        wr_note = cmd_reg.note_num;
                        wr_end = cmd_reg.end_ms;
                    end else begin
                        ob_next = mk(EV_OVER, cmd_reg.channel, cmd_reg.note_num,
                                     7'd0, 7'd0, 6'd0);
                    end
                    st_next = ST_MIN;
                    idx_next = 6'd0;
                    has_next = 1'b0;
                    best_next = 32'd0;
                end
            end
            ST_MIN: begin
                if (idx_reg >= cnt_reg) begin
                    st_next = ST_DONE;
                end else begin
                    if (!has_reg || tend[ci] < best_reg) begin
                        best_next = tend[ci];
                        has_next = 1'b1;
                    end
                    idx_next = idx_reg + 6'd1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    ov_next = 1'b1;
                    ob_next = mk(EV_DONE, 4'd0, 7'd0, 7'd0, 7'd0, 6'd0);
                    ob_next.next_end_ms = best_reg;
                    ob_next.has_next_end = has_reg;
                    ob_next.last = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
        // A newly loaded beat takes the voice count found by the scan.
        if (ov_next && !(ov_reg && !m_ready)) ob_next.active_voices = fin_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            cnt_reg <= 6'd0;
            ov_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            cnt_reg <= cnt_next;
            ov_reg <= ov_next;
        end
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        found_reg <= found_next;
        match_reg <= match_next;
        best_reg <= best_next;
        has_reg <= has_next;
        ob_reg <= ob_next;
        fin_reg <= fin_next;
        pcnt_reg <= pcnt_next;
        pfound_reg <= pfound_next;
        if (wr_en) begin
            tch[wr_idx] <= wr_ch;
            tnote[wr_idx] <= wr_note;
            tend[wr_idx] <= wr_end;
        end
    end

    `MANT_ASSERT(a_cnt_max, aclk, aresetn, cnt_reg <= VMAX, "voice count over capacity")
    `MANT_ASSERT(a_hold, aclk, aresetn, (m_valid && !m_ready) |=> $stable(m_beat), "beat changed while stalled")
    `MANT_ASSERT(a_idle_pop, aclk, aresetn, q_pop |-> (st_reg == ST_IDLE), "pop while busy")
endmodule

[hdl/midi_active_note_tracker.sv]
// ----------------------------------------------------------------------------
// midi_active_note_tracker
// Voice table of a MIDI sequencer: expires, retriggers and starts notes.
// ----------------------------------------------------------------------------
// The s_ channel carries tick, note and release items; the m_ channel returns
// note-off, program change, note-on and overflow beats, and always a final
// done beat (last high) with the earliest remaining end time.
// A two-entry command queue lets the front accept items while the back walks
// the voice table. The back handles one item at a time and takes a new one
// from the queue only once the done beat of the last is loaded. Each item runs
// a scan that counts the surviving voices, the expiry walk, the minimum search
// and a few fixed steps; these walks over the table set the item rate.
// Reset clears the voice count and all channel programs; table contents are
// not cleared. A stalled receiver holds the output register; the back stops
// and the queue fills, after which s_ready drops.
// ----------------------------------------------------------------------------
module midi_active_note_tracker
    import mant_pkg::*;
#(
    parameter int VOICES   = 32,
    parameter int CHANNELS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_beat_t  s_data,
    input  logic      s_valid,
    output logic      s_ready,
    output out_beat_t m_data,
    output logic      m_valid,
    input  logic      m_ready
);
    cmd_t q_cmd;
    logic q_valid, q_pop;

    mant_front #(.CHANNELS(CHANNELS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .s_beat(s_data), .s_valid(s_valid),
        .s_ready(s_ready), .q_cmd(q_cmd), .q_valid(q_valid), .q_pop(q_pop)
    );

    mant_back #(.VOICES(VOICES)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_cmd(q_cmd), .q_valid(q_valid),
        .q_pop(q_pop), .m_beat(m_data), .m_valid(m_valid), .m_ready(m_ready)
    );
endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Active note tracker testbench
// Drives tick, note and release items through the voice table under random
// idling on both sides, and checks every result beat field by field against
// an internal model of the voice table and channel programs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import mant_pkg::*;

    localparam int VOICES   = 32;
    localparam int CHANNELS = 16;

    // Scoreboard: a model of the voice table and a queue of pending beats.
    class note_scoreboard;
        logic [3:0]  v_chan [VOICES];
        logic [6:0]  v_note [VOICES];
        logic [31:0] v_end  [VOICES];
        int          voice_cnt;
        logic [6:0]  chan_prog [CHANNELS];
        out_beat_t   pending [$];
        int          errors;
        int          beats_seen;

        function void clear();
            voice_cnt = 0;
            foreach (chan_prog[c]) chan_prog[c] = '0;
            pending.delete();
            errors = 0;
            beats_seen = 0;
        endfunction

        function void push(logic [2:0] ev, logic [3:0] ch, logic [6:0] nt,
                           logic [6:0] vel, logic [6:0] pg);
            out_beat_t b;
            b = '0;
            b.event_res = ev;
            b.out_channel = ch;
            b.out_note = nt;
            b.out_velocity = vel;
            b.out_program = pg;
            pending.push_back(b);
        endfunction

        function void note_item(in_beat_t it);
            int first;
            int i;
            int t;
            int match;
            bit found;
            logic [31:0] best;
            bit has;
            first = pending.size();
            found = 0;
            match = 0;
            if (it.kind == KIND_RELEASE) begin
                for (i = 0; i < voice_cnt; i++) push(EV_OFF, v_chan[i], v_note[i], '0, '0);
                voice_cnt = 0;
            end else begin
                i = 0;
                while (i < voice_cnt) begin
                    if (v_end[i] <= it.now_ms) begin
                        push(EV_OFF, v_chan[i], v_note[i], '0, '0);
                        t = voice_cnt - 1;
                        v_chan[i] = v_chan[t];
                        v_note[i] = v_note[t];
                        v_end[i] = v_end[t];
                        voice_cnt--;
                    end else begin
                        if (it.kind == KIND_NOTE && v_chan[i] == it.channel &&
                            v_note[i] == it.note_num) begin
                            found = 1;
                            match = i;
                        end
                        i++;
                    end
                end
                if (it.kind == KIND_NOTE) begin
                    if (chan_prog[it.channel] != it.program_req) begin
                        push(EV_PROG, it.channel, '0, '0, it.program_req);
                        chan_prog[it.channel] = it.program_req;
                    end
                    if (found) begin
                        push(EV_OFF, it.channel, it.note_num, '0, '0);
                    end else if (voice_cnt < VOICES) begin
                        match = voice_cnt;
                        voice_cnt++;
                        found = 1;
                    end
                    if (found) begin
                        push(EV_ON, it.channel, it.note_num, it.velocity, '0);
                        v_chan[match] = it.channel;
                        v_note[match] = it.note_num;
                        v_end[match] = it.end_ms;
                    end else begin
                        push(EV_OVER, it.channel, it.note_num, '0, '0);
                    end
                end
            end
            best = '0;
            has = 0;
            for (i = 0; i < voice_cnt; i++) begin
                if (!has || v_end[i] < best) begin
                    best = v_end[i];
                    has = 1;
                end
            end
            push(EV_DONE, '0, '0, '0, '0);
            pending[pending.size()-1].next_end_ms = best;
            pending[pending.size()-1].has_next_end = has;
            pending[pending.size()-1].last = 1'b1;
            for (i = first; i < pending.size(); i++)
                pending[i].active_voices = voice_cnt[5:0];
        endfunction

        task check_beat(out_beat_t got);
            out_beat_t want;
            beats_seen++;
            if (pending.size() == 0) begin
                report("unexpected beat", got, '0);
                return;
            end
            want = pending.pop_front();
            if (got.event_res !== want.event_res) report("event_res", got, want);
            if (got.out_channel !== want.out_channel) report("out_channel", got, want);
            if (got.out_note !== want.out_note) report("out_note", got, want);
            if (got.out_velocity !== want.out_velocity) report("out_velocity", got, want);
            if (got.out_program !== want.out_program) report("out_program", got, want);
            if (got.next_end_ms !== want.next_end_ms) report("next_end_ms", got, want);
            if (got.has_next_end !== want.has_next_end) report("has_next_end", got, want);
            if (got.active_voices !== want.active_voices) report("active_voices", got, want);
            if (got.last !== want.last) report("last", got, want);
        endtask

        task report(string what, out_beat_t got, out_beat_t want);
            errors++;
            $display("MISMATCH %s at %0t: got %h want %h", what, $time, got, want);
        endtask
    endclass

    logic      aclk;
    logic      aresetn;
    in_beat_t  s_data;
    logic      s_valid;
    logic      s_ready;
    out_beat_t m_data;
    logic      m_valid;
    logic      m_ready;

    note_scoreboard board;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;
    int items_sent;
    logic [31:0] clock_ms;

    midi_active_note_tracker #(.VOICES(VOICES), .CHANNELS(CHANNELS)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_data(s_data), .s_valid(s_valid), .s_ready(s_ready),
        .m_data(m_data), .m_valid(m_valid), .m_ready(m_ready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("timeout with %0d beats outstanding", board.pending.size());
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off when requested.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) board.check_beat(m_data);
            m_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Valid stays high from one item to the next unless the sender idles.
    task automatic send_item(in_beat_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_data <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_item(it);
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic in_beat_t make_item(logic [1:0] k, logic [3:0] ch, logic [6:0] nt,
                                           logic [31:0] dur);
        in_beat_t it;
        it.kind = k;
        it.now_ms = clock_ms;
        it.channel = ch;
        it.note_num = nt;
        it.velocity = 7'($urandom_range(127));
        it.program_req = 7'($urandom_range(3));
        it.end_ms = clock_ms + dur;
        return it;
    endfunction

    // Mostly a well-formed stretch: time moves forward and notes come from a small pool, apart from noise items.
    task automatic random_item();
        in_beat_t it;
        int r;
        r = $urandom_range(99);
        clock_ms = clock_ms + $urandom_range(20);
        if (r < 70) begin
            it = make_item(KIND_NOTE, 4'($urandom_range(3)), 7'(60 + $urandom_range(7)),
                           $urandom_range(1, 150));
        end else if (r < 85) begin
            it = make_item(KIND_TICK, '0, '0, '0);
            it.channel = 4'($urandom);
            it.note_num = 7'($urandom);
        end else if (r < 90) begin
            it = make_item(KIND_RELEASE, 4'($urandom), 7'($urandom), '0);
        end else if (r < 93) begin
            it = make_item(KIND_SPARE, '0, '0, '0);
        end else begin
            // Noise: fully random fields, time may jump anywhere.
            it = make_item(KIND_TICK, 4'($urandom), 7'($urandom), '0);
            it.now_ms = $urandom;
            it.end_ms = $urandom;
            it.kind = $urandom_range(1) ? KIND_NOTE : KIND_TICK;
            it.velocity = 7'($urandom);
            it.program_req = 7'($urandom);
            clock_ms = it.now_ms;
        end
        send_item(it);
    endtask

    task automatic run_phase(int idle, int stall, int count);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count) random_item();
    endtask

    initial begin
        in_beat_t it;
        int i;
        board = new();
        board.clear();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        items_sent = 0;
        clock_ms = 32'd100;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, program change, retrigger, unknown kind, overflow.
        it = '1;
        it.kind = KIND_NOTE;
        send_item(it);
        it = '0;
        it.kind = KIND_NOTE;
        it.end_ms = 32'hFFFF_FFFF;
        send_item(it);
        send_item(make_item(KIND_NOTE, 4'd15, 7'd127, 32'd10));
        send_item(make_item(KIND_NOTE, 4'd15, 7'd127, 32'd50));
        send_item(make_item(KIND_SPARE, '0, '0, '0));
        it = '0;
        it.kind = KIND_TICK;
        it.now_ms = 32'hFFFF_FFFF;
        send_item(it);
        for (i = 0; i < 34; i++) begin
            it = make_item(KIND_NOTE, i[3:0], i[6:0], 32'(1000 + i));
            send_item(it);
        end
        send_item(make_item(KIND_RELEASE, '0, '0, '0));
        drain();

        run_phase(0, 0, 50);
        run_phase(51, 0, 50);
        run_phase(0, 51, 50);
        run_phase(18, 18, 40);

        // Receiver holds off while the sender keeps offering items.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge aclk);
                hold_off = 1'b0;
            end
            repeat (8) random_item();
        join
        // Sender pauses until every result has come back.
        drain();
        run_phase(0, 0, 30);
        drain();

        $display("Sent %0d items and checked %0d result beats across idle and stall phases,",
                 items_sent, board.beats_seen);
        $display("including table overflow, retriggers, releases and long hold-offs.");
        if (board.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+hdl
hdl/mant_pkg.sv
hdl/mant_front.sv
hdl/mant_back.sv
hdl/midi_active_note_tracker.sv
tb/tb.sv
